### design/fqu_pkg.sv
// fqu_pkg: shared types, codes and helpers for the keyed-quantity fifo
// used by fqu_cell, fifo_with_keyed_quantity_update and its checker
package fqu_pkg;

	localparam int unsigned QueueDepth = 16;
	localparam int unsigned CntW       = $clog2(QueueDepth + 1);
	localparam int unsigned DataW      = 32;
	localparam int unsigned OutCntW    = 5;

	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_POP  = 2'd1;
	localparam logic [1:0] ACT_SUB  = 2'd2;
	localparam logic [1:0] ACT_ADD  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// command broadcast to every cell
	typedef struct packed {
		logic              push;
		logic              pop;
		logic              upd;
		logic              sub;
		logic [DataW-1:0]  code;
		logic [DataW-1:0]  amount;
	} fqu_cmd_t;

	// per-cell position relative to the fill level
	typedef struct packed {
		logic held;
		logic tail;
	} fqu_slot_t;

	function automatic logic [DataW-1:0] sat_update(input logic [DataW-1:0] q,
			input logic [DataW-1:0] d, input logic sub);
		logic [DataW:0] s;
		logic [DataW:0] qx;
		logic [DataW:0] dx;
		qx = {q[DataW-1], q};
		dx = {d[DataW-1], d};
		s  = sub ? (qx - dx) : (qx + dx);
		if (s[DataW] != s[DataW-1]) begin
			sat_update = s[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
		end else begin
			sat_update = s[DataW-1:0];
		end
	endfunction

endpackage

### design/fqu_cell.sv
// fqu_cell: one fifo slot holding code and quantity, shifts toward the head on pop
// depends on fqu_pkg
module fqu_cell (
	input  logic                      clk,
	input  fqu_pkg::fqu_cmd_t         cmd,
	input  fqu_pkg::fqu_slot_t        slot,
	input  logic [fqu_pkg::DataW-1:0] nxt_code,
	input  logic [fqu_pkg::DataW-1:0] nxt_amount,
	output logic [fqu_pkg::DataW-1:0] code,
	output logic [fqu_pkg::DataW-1:0] amount,
	output logic                      match
);

	logic [fqu_pkg::DataW-1:0] code_q;
	logic [fqu_pkg::DataW-1:0] amount_q;

	assign match  = cmd.upd && slot.held && (code_q == cmd.code);
	assign code   = code_q;
	assign amount = amount_q;

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			code_q   <= nxt_code;
			amount_q <= nxt_amount;
		end else if (cmd.push && slot.tail) begin
			code_q   <= cmd.code;
			amount_q <= cmd.amount;
		end else if (match) begin
			amount_q <= fqu_pkg::sat_update(amount_q, cmd.amount, cmd.sub);
		end
	end

endmodule

### design/fifo_with_keyed_quantity_update.sv
// fifo_with_keyed_quantity_update: top level, a row of fqu_cell slots plus output register
// depends on fqu_pkg and fqu_cell
//
// usage
//   input stream s_*: one action per transfer, s_tuser selects push, pop, subtract
//   or add; s_tdata carries the item code and the amount
//   output stream m_*: exactly one result per input transfer, in order; m_tuser is
//   the status, m_tdata holds popped code and quantity, match count and occupancy
//   entries live in a row of cells, the head always in the first cell; a pop shifts
//   every cell one place toward the head, a push writes the cell at the fill level,
//   and an update compares the code in every held cell at once and applies the
//   saturating add or subtract where it matches
//   result: held in the output register, appears in the cycle after the input transfer
//   throughput: one action per cycle while results are taken, set by the single output register
//   reset clears the fill level and the output valid flag; slot contents and output
//   data are left as they are and are never read before written
//   a stalled receiver holds the result; s_tready stays high while the output
//   register is empty or is being taken in the same cycle
module fifo_with_keyed_quantity_update (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // item_code, item_amount
	input  logic [1:0]  s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // head_code, head_amount, match_count, occupancy, zero pad
	output logic [1:0]  m_tuser   // status
);

	localparam int unsigned D  = fqu_pkg::QueueDepth;
	localparam int unsigned CW = fqu_pkg::CntW;
	localparam int unsigned DW = fqu_pkg::DataW;
	localparam int unsigned OW = fqu_pkg::OutCntW;

	logic                 take;
	logic                 full;
	logic                 empty;
	fqu_pkg::fqu_cmd_t    cmd;
	fqu_pkg::fqu_slot_t   slot [D];
	logic [DW-1:0]        cell_code   [D];
	logic [DW-1:0]        cell_amount [D];
	logic [D-1:0]         match_vec;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_nxt;
	logic [CW-1:0]        match_cnt;
	logic                 m_tvalid_q;
	logic [1:0]           status_q;
	logic [DW-1:0]        head_code_q;
	logic [DW-1:0]        head_amount_q;
	logic [OW-1:0]        match_q;
	logic [OW-1:0]        occ_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign take     = s_tvalid && s_tready;
	assign full     = (count_q >= CW'(D));
	assign empty    = (count_q == '0);

	assign cmd.push   = take && (s_tuser == fqu_pkg::ACT_PUSH) && !full;
	assign cmd.pop    = take && (s_tuser == fqu_pkg::ACT_POP) && !empty;
	assign cmd.upd    = take && ((s_tuser == fqu_pkg::ACT_SUB) || (s_tuser == fqu_pkg::ACT_ADD));
	assign cmd.sub    = (s_tuser == fqu_pkg::ACT_SUB);
	assign cmd.code   = s_tdata[DW-1:0];
	assign cmd.amount = s_tdata[2*DW-1:DW];

	for (genvar i = 0; i < D; i++) begin : g_cell
		logic [DW-1:0] nc;
		logic [DW-1:0] na;
		assign slot[i].held = (CW'(i) < count_q);
		assign slot[i].tail = (CW'(i) == count_q);
		if (i == D - 1) begin : g_last
			assign nc = '0;
			assign na = '0;
		end else begin : g_mid
			assign nc = cell_code[i+1];
			assign na = cell_amount[i+1];
		end
		fqu_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.slot       (slot[i]),
			.nxt_code   (nc),
			.nxt_amount (na),
			.code       (cell_code[i]),
			.amount     (cell_amount[i]),
			.match      (match_vec[i])
		);
	end

	assign match_cnt = CW'($countones(match_vec));

	always_comb begin
		count_nxt = count_q;
		if (cmd.push) begin
			count_nxt = count_q + CW'(1);
		end else if (cmd.pop) begin
			count_nxt = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (take) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q      <= fqu_pkg::ST_OK;
			head_code_q   <= '0;
			head_amount_q <= '0;
			match_q       <= OW'(match_cnt);
			occ_q         <= OW'(count_nxt);
			case (s_tuser)
				fqu_pkg::ACT_PUSH: begin
					if (full) begin
						status_q <= fqu_pkg::ST_FULL;
					end
				end
				fqu_pkg::ACT_POP: begin
					if (empty) begin
						status_q <= fqu_pkg::ST_EMPTY;
					end else begin
						head_code_q   <= cell_code[0];
						head_amount_q <= cell_amount[0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {6'd0, occ_q, match_q, head_amount_q, head_code_q};

endmodule

### design/fqu_checker.sv
// fqu_checker: port-level assertions for fifo_with_keyed_quantity_update, bound to the top level
// depends on fqu_pkg
module fqu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// result held while the receiver stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed under stall");

	// full status only at full occupancy
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == fqu_pkg::ST_FULL) |-> (m_tdata[73:69] == 5'(fqu_pkg::QueueDepth)))
		else $error("full reported below depth");

	// empty pop returns zero fields at zero occupancy
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == fqu_pkg::ST_EMPTY) |->
			(m_tdata[73:0] == 74'd0))
		else $error("empty pop with nonzero fields");

	// matches never exceed held entries
	a_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[68:64] <= m_tdata[73:69]))
		else $error("match count above occupancy");

	// every accepted transfer produces a valid result
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted transfer produced no result");

endmodule

bind fifo_with_keyed_quantity_update fqu_checker u_fqu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### tb/sv/tb.sv
// tb: self-checking testbench for fifo_with_keyed_quantity_update
// drives actions on the input stream, predicts each result and checks the output stream
// depends on fqu_pkg and the design files under design/
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 400000;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] head_code;
		logic [31:0] head_amount;
		logic [4:0]  match_count;
		logic [4:0]  occupancy;
	} qty_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;  // item_code, item_amount
	logic [1:0]  s_tuser;  // action
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;  // head_code, head_amount, match_count, occupancy, zero pad
	logic [1:0]  m_tuser;  // status

	logic [31:0] held_code[$];
	logic [31:0] held_qty[$];
	qty_result_t pending_results[$];

	int errors;
	int cycles;
	int hold_left;
	int stall_left;
	bit tx_idle_on;
	bit rx_idle_on;
	int n_sent, n_checked, n_full, n_empty, n_matched, n_clamped;

	fifo_with_keyed_quantity_update u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int pick_gap(input bit on);
		int r;
		r = $urandom_range(0, 99);
		if (!on || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic [31:0] clamp_qty(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	// stock queue model, head at index 0
	task automatic apply_action(input logic [1:0] act, input logic [31:0] code,
			input logic [31:0] amt);
		qty_result_t res;
		longint q;
		longint d;
		longint r;
		res = '{fqu_pkg::ST_OK, 32'd0, 32'd0, 5'd0, 5'd0};
		case (act)
			fqu_pkg::ACT_PUSH: begin
				if (held_code.size() >= fqu_pkg::QueueDepth) begin
					res.status = fqu_pkg::ST_FULL;
					n_full++;
				end else begin
					held_code.push_back(code);
					held_qty.push_back(amt);
				end
			end
			fqu_pkg::ACT_POP: begin
				if (held_code.size() == 0) begin
					res.status = fqu_pkg::ST_EMPTY;
					n_empty++;
				end else begin
					res.head_code = held_code.pop_front();
					res.head_amount = held_qty.pop_front();
				end
			end
			default: begin
				d = longint'($signed(amt));
				foreach (held_code[i]) begin
					if (held_code[i] == code) begin
						q = longint'($signed(held_qty[i]));
						r = (act == fqu_pkg::ACT_SUB) ? q - d : q + d;
						held_qty[i] = clamp_qty(r);
						if (held_qty[i] != r[31:0] || r > 64'sd2147483647
								|| r < -64'sd2147483648)
							n_clamped++;
						res.match_count++;
					end
				end
				if (res.match_count != 0)
					n_matched++;
			end
		endcase
		res.occupancy = 5'(held_code.size());
		pending_results.push_back(res);
	endtask

	// entered and left at a falling edge; tvalid stays up for a back-to-back transfer
	task automatic send_action(input logic [1:0] act, input logic [31:0] code,
			input logic [31:0] amt);
		int gap;
		gap = pick_gap(tx_idle_on);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {amt, code};
		do @(posedge clk); while (!s_tready);
		apply_action(act, code, amt);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic make_random(input int push_pct, output logic [1:0] act,
			output logic [31:0] code, output logic [31:0] amt);
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			act = ($urandom_range(0, 1) != 0) ? fqu_pkg::ACT_ADD : fqu_pkg::ACT_SUB;
		else if (r < 25 + push_pct * 75 / 100)
			act = fqu_pkg::ACT_PUSH;
		else
			act = fqu_pkg::ACT_POP;
		r = $urandom_range(0, 99);
		if (act != fqu_pkg::ACT_PUSH && act != fqu_pkg::ACT_POP && held_code.size() != 0
				&& r < 75)
			code = held_code[$urandom_range(0, held_code.size() - 1)];
		else if (r < 85) begin
			case ($urandom_range(0, 4))
				0: code = 32'h0;
				1: code = 32'hffffffff;
				2: code = 32'h7fffffff;
				3: code = 32'h80000000;
				default: code = 32'd42;
			endcase
		end else
			code = $urandom;
		r = $urandom_range(0, 99);
		if (r < 40)
			amt = $urandom_range(0, 200) - 100;
		else if (r < 65)
			amt = ($urandom_range(0, 1) != 0) ? 32'h7fffffff - $urandom_range(0, 15)
				: 32'h80000000 + $urandom_range(0, 15);
		else
			amt = $urandom;
	endtask

	task automatic test_empty_queue();
		send_action(fqu_pkg::ACT_POP, 32'h12345678, 32'h0);
		send_action(fqu_pkg::ACT_ADD, 32'h0, 32'd5);
	endtask

	task automatic test_fill_and_saturate();
		logic [31:0] code;
		logic [31:0] amt;
		for (int i = 0; i < fqu_pkg::QueueDepth; i++) begin
			case (i % 5)
				0: code = 32'h7fffffff;
				1: code = 32'h80000000;
				2: code = 32'h0;
				3: code = 32'hffffffff;
				default: code = 100 + i;
			endcase
			amt = (i % 2 != 0) ? 32'h7ffffff0 + i : 32'h80000000 + i;
			send_action(fqu_pkg::ACT_PUSH, code, amt);
		end
		send_action(fqu_pkg::ACT_PUSH, 32'd77, 32'd77);
		send_action(fqu_pkg::ACT_ADD, 32'h7fffffff, 32'h7fffffff);
		send_action(fqu_pkg::ACT_SUB, 32'h80000000, 32'h7fffffff);
		send_action(fqu_pkg::ACT_ADD, 32'h80000000, 32'h80000000);
		send_action(fqu_pkg::ACT_SUB, 32'h0, 32'h80000000);
		send_action(fqu_pkg::ACT_SUB, 32'd12345, 32'd1);
		send_action(fqu_pkg::ACT_POP, 32'h0, 32'h0);
		send_action(fqu_pkg::ACT_POP, 32'hffffffff, 32'hffffffff);
	endtask

	task automatic test_receiver_hold();
		logic [1:0] act;
		logic [31:0] code;
		logic [31:0] amt;
		tx_idle_on = 1'b0;
		hold_left = 120;
		repeat (24) begin
			make_random(50, act, code, amt);
			send_action(act, code, amt);
		end
	endtask

	task automatic test_random_mix(input int count);
		logic [1:0] act;
		logic [31:0] code;
		logic [31:0] amt;
		int push_pct;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 20;
					1: push_pct = 50;
					default: push_pct = 85;
				endcase
				tx_idle_on = $urandom_range(0, 1);
				rx_idle_on = $urandom_range(0, 1);
			end
			if (i == count / 2)
				wait_results_done();
			make_random(push_pct, act, code, amt);
			send_action(act, code, amt);
		end
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				stall_left = pick_gap(rx_idle_on);
			end
		end
	end

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h actual %h", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_results
		qty_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected transfer, expected none actual %h/%h", $time,
					m_tuser, m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(m_tuser));
				check_field("head_code", want.head_code, m_tdata[31:0]);
				check_field("head_amount", want.head_amount, m_tdata[63:32]);
				check_field("match_count", 32'(want.match_count), 32'(m_tdata[68:64]));
				check_field("occupancy", 32'(want.occupancy), 32'(m_tdata[73:69]));
				n_checked++;
			end
		end
	end

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		arst_n = 1'b0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_empty_queue();
		test_fill_and_saturate();
		test_receiver_hold();
		test_random_mix(400);
		rx_idle_on = 1'b0;
		wait_results_done();
		repeat (4) @(posedge clk);
		$display("%0d actions sent, %0d results checked", n_sent, n_checked);
		$display("%0d full pushes, %0d empty pops, %0d updates with matches, %0d clamped",
			n_full, n_empty, n_matched, n_clamped);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### fifo_with_keyed_quantity_update.f
design/fqu_pkg.sv
design/fqu_cell.sv
design/fifo_with_keyed_quantity_update.sv
design/fqu_checker.sv
tb/sv/tb.sv
